### rtl/rtr_pkg.sv
`timescale 1ns / 1ps

package rtr_pkg;

   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned RAW_WIDTH   = 31;
   localparam int unsigned SPAN_WIDTH  = VALUE_WIDTH + 1;
   localparam int unsigned COUNT_WIDTH = $clog2(RAW_WIDTH);

   localparam logic [VALUE_WIDTH-1:0] SEED_VALUE = 32'd12345;
   localparam logic [VALUE_WIDTH-1:0] MASK_ONE   = 32'hFFFF_FFFE;
   localparam logic [VALUE_WIDTH-1:0] MASK_TWO   = 32'hFFFF_FFF8;
   localparam logic [VALUE_WIDTH-1:0] MASK_THREE = 32'hFFFF_FFF0;
   localparam logic [VALUE_WIDTH-1:0] MASK_FOUR  = 32'hFFFF_FF80;
   localparam logic [VALUE_WIDTH-1:0] SIGN_FLIP  = 32'h8000_0000;

   localparam logic [COUNT_WIDTH-1:0] LAST_BIT = COUNT_WIDTH'(RAW_WIDTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SPAN = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] c1;
      logic [VALUE_WIDTH-1:0] c2;
      logic [VALUE_WIDTH-1:0] c3;
      logic [VALUE_WIDTH-1:0] c4;
   } gen_type;

   function automatic gen_type gen_step(input gen_type g);
      gen_type r;
      r.c1 = ((g.c1 & MASK_ONE) << 18)   ^ (((g.c1 << 6) ^ g.c1) >> 13);
      r.c2 = ((g.c2 & MASK_TWO) << 2)    ^ (((g.c2 << 2) ^ g.c2) >> 27);
      r.c3 = ((g.c3 & MASK_THREE) << 7)  ^ (((g.c3 << 13) ^ g.c3) >> 21);
      r.c4 = ((g.c4 & MASK_FOUR) << 13)  ^ (((g.c4 << 3) ^ g.c4) >> 12);
      return r;
   endfunction

endpackage

### rtl/ranged_tausworthe_random.sv
`timescale 1ns / 1ps

// channel | dir | tdata fields, lowest bit up
// req     | in  | lo_bound[31:0], hi_bound[63:32]
// rsp     | out | ranged_value[31:0], raw_value[62:32], zero[63]
//
// once a request is accepted, ST_SPAN orders the bounds and forms the span,
// ST_DIV steps the shared radix-2 compare-and-subtract unit through the raw
// value from its top bit, one remainder step per raw bit, and ST_DONE does the
// final add and loads the result; the next request is taken in ST_IDLE after that
// synchronous reset loads all four generator components with 12345
// a request is taken while a result waits; the final add holds until it leaves

module ranged_tausworthe_random (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // lo_bound, hi_bound
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // ranged_value, raw_value, zero pad
);

   rtr_pkg::state_type state_ff, state_in;
   rtr_pkg::gen_type   gen_ff, gen_in, gen_next;

   logic [rtr_pkg::VALUE_WIDTH-1:0] a_ff, a_in, b_ff, b_in;
   logic [rtr_pkg::VALUE_WIDTH-1:0] lo_ff, lo_in;
   logic [rtr_pkg::SPAN_WIDTH-1:0]  span_ff, span_in;
   logic [rtr_pkg::RAW_WIDTH-1:0]   raw_ff, raw_in;
   logic [rtr_pkg::RAW_WIDTH-1:0]   rem_ff, rem_in;
   logic [rtr_pkg::COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                            out_valid_ff, out_valid_in;
   logic [rtr_pkg::VALUE_WIDTH-1:0] out_value_ff, out_value_in;
   logic [rtr_pkg::RAW_WIDTH-1:0]   out_raw_ff, out_raw_in;

   logic                            req_take;
   logic                            swap;
   logic [rtr_pkg::VALUE_WIDTH-1:0] hi_sel, lo_sel;
   logic [rtr_pkg::VALUE_WIDTH-1:0] gen_xor;
   logic [rtr_pkg::VALUE_WIDTH-1:0] shifted;
   logic [rtr_pkg::SPAN_WIDTH-1:0]  trial;
   logic                            fits;
   logic                            out_free;

   assign req_tready = (state_ff == rtr_pkg::ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign gen_next = rtr_pkg::gen_step(gen_ff);
   assign gen_xor  = gen_next.c1 ^ gen_next.c2 ^ gen_next.c3 ^ gen_next.c4;

   // signed order of the bounds via offset binary
   assign swap   = (b_ff ^ rtr_pkg::SIGN_FLIP) < (a_ff ^ rtr_pkg::SIGN_FLIP);
   assign lo_sel = swap ? b_ff : a_ff;
   assign hi_sel = swap ? a_ff : b_ff;

   // shared compare-and-subtract unit
   assign shifted = {rem_ff, raw_ff[cnt_ff]};
   assign trial   = {1'b0, shifted} - span_ff;
   assign fits    = ({1'b0, shifted} >= span_ff);

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      raw_in       = raw_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_raw_in   = out_raw_ff;
      case (state_ff)
         rtr_pkg::ST_IDLE: begin
            if (req_take) begin
               a_in     = req_tdata[31:0];
               b_in     = req_tdata[63:32];
               gen_in   = gen_next;
               raw_in   = gen_xor[rtr_pkg::VALUE_WIDTH-1:1];
               state_in = rtr_pkg::ST_SPAN;
            end
         end
         rtr_pkg::ST_SPAN: begin
            lo_in    = lo_sel;
            span_in  = {1'b0, hi_sel - lo_sel} + rtr_pkg::SPAN_WIDTH'(1);
            rem_in   = '0;
            cnt_in   = rtr_pkg::LAST_BIT;
            state_in = rtr_pkg::ST_DIV;
         end
         rtr_pkg::ST_DIV: begin
            rem_in = fits ? trial[rtr_pkg::RAW_WIDTH-1:0] : shifted[rtr_pkg::RAW_WIDTH-1:0];
            cnt_in = cnt_ff - rtr_pkg::COUNT_WIDTH'(1);
            if (cnt_ff == '0) begin
               state_in = rtr_pkg::ST_DONE;
            end
         end
         rtr_pkg::ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = lo_ff + {1'b0, rem_ff};
               out_raw_in   = raw_ff;
               state_in     = rtr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rtr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtr_pkg::ST_IDLE;
         gen_ff       <= '{rtr_pkg::SEED_VALUE, rtr_pkg::SEED_VALUE,
                           rtr_pkg::SEED_VALUE, rtr_pkg::SEED_VALUE};
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      lo_ff        <= lo_in;
      span_ff      <= span_in;
      raw_ff       <= raw_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      out_value_ff <= out_value_in;
      out_raw_ff   <= out_raw_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_raw_ff, out_value_ff};

endmodule
